// ===== rtl/core/pvau_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pvau_pkg
// Shared register indexes, constants and raster-op functions of the planar VRAM access unit.
// ---------------------------------------------------------------------------
package pvau_pkg;

   localparam int MEM_BYTES_DEF = 262144;

   localparam logic [1:0] OP_READ_BYTE  = 2'd0;
   localparam logic [1:0] OP_WRITE_BYTE = 2'd1;
   localparam logic [1:0] OP_READ_WORD  = 2'd2;
   localparam logic [1:0] OP_WRITE_WORD = 2'd3;

   localparam logic [2:0] CSR_MODE    = 3'd0;
   localparam logic [2:0] CSR_MASKS   = 3'd1;
   localparam logic [2:0] CSR_ACCESS  = 3'd2;
   localparam logic [2:0] CSR_ROP     = 3'd3;
   localparam logic [2:0] CSR_COMPARE = 3'd4;
   localparam logic [2:0] CSR_PATTERN = 3'd5;

   localparam logic [1:0] WM_ROP     = 2'd0;
   localparam logic [1:0] WM_PATTERN = 2'd1;
   localparam logic [1:0] WM_CPU     = 2'd2;
   localparam logic [1:0] WM_NOP     = 2'd3;

   localparam logic [3:0] WAIT_SINGLE_R = 4'd4;
   localparam logic [3:0] WAIT_MULTI_R  = 4'd7;
   localparam logic [3:0] WAIT_SINGLE_W = 4'd1;
   localparam logic [3:0] WAIT_MULTI_W  = 4'd4;

   // 8-bit raster-op: each rop bit selects one minterm of (pattern, cpu, mem)
   function automatic logic [7:0] rop_byte(input logic [7:0] rop, input logic [7:0] p,
                                           input logic [7:0] c, input logic [7:0] m);
      logic [7:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         if (rop[k]) begin
            r = r | ((k[2] ? p : ~p) & (k[1] ? c : ~c) & (k[0] ? m : ~m));
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] write_sel(input logic [1:0] mode, input logic [7:0] rop,
                                            input logic [7:0] p, input logic [7:0] c,
                                            input logic [7:0] m);
      logic [7:0] r;
      case (mode)
         WM_ROP:     r = rop_byte(rop, p, c, m);
         WM_PATTERN: r = p;
         WM_CPU:     r = c;
         default:    r = m;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/pvau_vram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pvau_vram
// Single-port byte store with registered read and a clearing sweep after reset.
// ---------------------------------------------------------------------------
module pvau_vram #(
   parameter int MEM_BYTES = pvau_pkg::MEM_BYTES_DEF,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata,
   output logic          busy
);
   logic [7:0]    mem [MEM_BYTES];
   logic [AW:0]   clr_ff, clr_in;
   logic [7:0]    rdata_ff;

   assign busy   = ~clr_ff[AW];
   assign clr_in = busy ? clr_ff + 1'b1 : clr_ff;
   assign rdata  = rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_ff[AW-1:0]] <= 8'h00;
      end else if (en && we) begin
         mem[addr] <= wdata;
      end
      if (en) begin
         rdata_ff <= mem[addr];
      end
   end
endmodule

// ===== rtl/core/planar_vram_access_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// planar_vram_access_unit
// CPU byte/word access controller for a planar graphics store.
// ---------------------------------------------------------------------------
// Usage:
//  req_* carries one access (opcode, address, write_data) on valid/ready.
//  rsp_* returns read_data and wait_cycles on valid/ready, one per request.
//  csr_* writes configuration registers 0..5 with csr_write_en; write only
//  while idle.
//  A sequencer steps one byte of the store at a time through a single
//  registered-read port: every byte passes a read state and a data state.
//  Steps outside extended mode: a byte read or direct byte write is one read
//  and one data step, a word read or direct word write does this per byte,
//  a single-plane byte write reads both bytes of the aligned word first, an
//  aligned single-plane word write then adds a step (S_HI) for the high byte,
//  and an odd one is two such byte writes. Extended mode visits four planes.
//  The next request can transfer in the cycle the response transfers.
//  After reset the store is swept to zero, one byte a cycle, and req_ready
//  stays low until the sweep ends.
//  A stalled receiver holds the response; req_ready stays low meanwhile.
// ---------------------------------------------------------------------------
module planar_vram_access_unit #(
   parameter int MEM_BYTES = pvau_pkg::MEM_BYTES_DEF,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_opcode,
   input  logic [17:0]   req_address,
   input  logic [15:0]   req_write_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [15:0]   rsp_read_data,
   output logic [3:0]    rsp_wait_cycles,
   input  logic          csr_write_en,
   input  logic [2:0]    csr_index,
   input  logic [47:0]   csr_write_data
);
   import pvau_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_DAT  = 2'd2;
   localparam logic [1:0] S_HI   = 2'd3;

   logic [4:0]  mode_ff;
   logic [7:0]  masks_ff, amb_ff;
   logic [47:0] rop_ff;
   logic [31:0] cmp_ff, spat_ff;

   logic [7:0]  pat_ff [8];
   logic [3:0]  prs_ff, pws_ff;

   logic [1:0]    st_ff, st_in;
   logic [1:0]    op_ff;
   logic [AW-1:0] addr_ff;
   logic [15:0]   wd_ff;
   logic          ext_ff;       // extended plane fan-out
   logic          pair_ff;      // aligned single-plane word write
   logic          bsel_ff;      // 0 first byte, 1 second byte (of item)
   logic [1:0]    plane_ff;
   logic [7:0]    acc_ff;       // plane accumulation
   logic [7:0]    lo_ff;        // first memory byte read (for rop word)
   logic          phase_ff;     // single write: 0 reading first, 1 reading second
   logic [7:0]    rd_ff;        // low byte of a word read
   logic [7:0]    hi_data_ff;   // high byte of an aligned single-plane word write

   logic          rsp_valid_ff;
   logic [15:0]   rsp_data_ff;
   logic [3:0]    rsp_wait_ff;

   logic          mem_en, mem_we, mem_busy;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata, mem_rdata;

   pvau_vram #(.MEM_BYTES(MEM_BYTES)) u_vram (
      .clock(clock), .reset(reset), .en(mem_en), .we(mem_we), .addr(mem_addr),
      .wdata(mem_wdata), .rdata(mem_rdata), .busy(mem_busy)
   );

   // ---- derived per-step values ----
   logic          is_wr, single, last_byte, plane_on, last_plane, latch_en;
   logic          sp_first, plane_more, byte_done, finish, req_fire;
   logic [AW-1:0] byte_addr, plane_addr, sp_base;
   logic [7:0]    cpu_byte, ppat, prop, pcmp, pwr, page_rop, acc_nx, bval;
   logic [15:0]   page_pat, cpu_word, sv_word, mem_word, rsp_data_in;

   assign is_wr      = op_ff[0];
   assign single     = mode_ff[0];
   assign last_byte  = ~op_ff[1] | bsel_ff;
   assign byte_addr  = addr_ff + AW'(bsel_ff);
   assign cpu_byte   = bsel_ff ? wd_ff[15:8] : wd_ff[7:0];
   assign plane_addr = {plane_ff, mode_ff[2], byte_addr[14:0]};
   // write disables sit in the upper nibble
   assign plane_on   = ~masks_ff[{is_wr, plane_ff}];
   assign last_plane = (plane_ff == 2'd3);
   assign latch_en   = is_wr ? amb_ff[1] : amb_ff[0];
   assign ppat = pat_ff[{plane_ff, prs_ff[plane_ff]}];
   assign prop = rop_ff[{plane_ff, 3'b000} +: 8];
   assign pcmp = cmp_ff[{plane_ff, 3'b000} +: 8];
   assign pwr  = write_sel(amb_ff[4:3], prop, ppat, cpu_byte, mem_rdata);
   assign acc_nx = acc_ff & (plane_on ? (amb_ff[5] ? ~(mem_rdata ^ pcmp) : mem_rdata)
                                      : 8'hff);
   assign bval = ext_ff ? acc_nx : mem_rdata;

   // single-plane: page from base address bit 17
   assign page_pat = byte_addr[AW-1] ? spat_ff[31:16] : spat_ff[15:0];
   assign page_rop = byte_addr[AW-1] ? rop_ff[47:40] : rop_ff[39:32];
   // mem_word: aligned pair; lo_ff holds base byte, rdata the next byte
   assign mem_word = {mem_rdata, lo_ff};
   assign cpu_word = pair_ff ? wd_ff :
                     (byte_addr[0] ? {cpu_byte, 8'h00} : {8'h00, cpu_byte});
   always_comb begin
      sv_word[7:0]  = write_sel(mode_ff[4:3], page_rop, page_pat[7:0], cpu_word[7:0],
                                mem_word[7:0]);
      sv_word[15:8] = write_sel(mode_ff[4:3], page_rop, page_pat[15:8], cpu_word[15:8],
                                mem_word[15:8]);
   end

   // single-plane write of one byte needs base and base+1 read first
   assign sp_base = {byte_addr[AW-1:1], 1'b0};

   assign sp_first   = ~ext_ff & single & is_wr & ~phase_ff;
   assign plane_more = ext_ff & ~last_plane;
   assign byte_done  = (st_ff == S_DAT) & ~sp_first & ~plane_more;
   assign finish     = (byte_done & ~pair_ff & last_byte) | (st_ff == S_HI);
   assign rsp_data_in = is_wr ? 16'h0000 : (bsel_ff ? {bval, rd_ff} : {8'h00, bval});

   assign req_ready = (st_ff == S_IDLE) & ~mem_busy & (~rsp_valid_ff | rsp_ready);
   assign req_fire  = req_valid & req_ready;

   // ---- memory port ----
   always_comb begin
      mem_en = 1'b0; mem_we = 1'b0; mem_addr = byte_addr; mem_wdata = 8'h00;
      case (st_ff)
         S_RD: begin
            mem_en = 1'b1;
            if (ext_ff) begin
               mem_addr = plane_addr;
            end else if (single && is_wr) begin
               mem_addr = sp_base + AW'(phase_ff);
            end
         end
         S_DAT: begin
            if (is_wr) begin
               if (ext_ff) begin
                  mem_en = plane_on; mem_we = plane_on; mem_addr = plane_addr;
                  mem_wdata = pwr;
               end else if (single) begin
                  if (phase_ff) begin
                     mem_en = 1'b1; mem_we = 1'b1;
                     mem_wdata = byte_addr[0] ? sv_word[15:8] : sv_word[7:0];
                  end
               end else begin
                  mem_en = 1'b1; mem_we = 1'b1; mem_wdata = cpu_byte;
               end
            end
         end
         S_HI: begin
            // second byte of the aligned word; bsel already points at it
            mem_en = 1'b1; mem_we = 1'b1; mem_wdata = hi_data_ff;
         end
         default: ;
      endcase
   end

   // ---- sequencer ----
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: begin
            if (req_fire) st_in = S_RD;
         end
         S_RD:    st_in = S_DAT;
         S_DAT: begin
            if (byte_done && pair_ff) st_in = S_HI;
            else if (byte_done && last_byte) st_in = S_IDLE;
            else st_in = S_RD;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0; masks_ff <= '0; amb_ff <= '0; rop_ff <= '0;
         cmp_ff <= '0; spat_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:    mode_ff  <= csr_write_data[4:0];
            CSR_MASKS:   masks_ff <= csr_write_data[7:0];
            CSR_ACCESS:  amb_ff   <= csr_write_data[7:0];
            CSR_ROP:     rop_ff   <= csr_write_data;
            CSR_COMPARE: cmp_ff   <= csr_write_data[31:0];
            CSR_PATTERN: spat_ff  <= csr_write_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rsp_valid_ff <= 1'b0; prs_ff <= '0; pws_ff <= '0;
         for (int i = 0; i < 8; i++) pat_ff[i] <= 8'h00;
      end else begin
         st_ff <= st_in;
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (finish) rsp_data_ff <= rsp_data_in;
         if (req_fire) begin
            op_ff <= req_opcode;
            addr_ff <= req_address[AW-1:0];
            wd_ff <= req_write_data;
            ext_ff <= ~mode_ff[0] & mode_ff[1];
            pair_ff <= mode_ff[0] & (req_opcode == OP_WRITE_WORD) & ~req_address[0];
            bsel_ff <= 1'b0; plane_ff <= 2'd0; acc_ff <= 8'hff; phase_ff <= 1'b0;
            if (req_opcode[0]) begin
               rsp_wait_ff <= (req_opcode[1] && req_address[0])
                  ? (mode_ff[0] ? 4'(2 * WAIT_SINGLE_W) : 4'(2 * WAIT_MULTI_W))
                  : (mode_ff[0] ? WAIT_SINGLE_W : WAIT_MULTI_W);
            end else begin
               rsp_wait_ff <= mode_ff[0] ? WAIT_SINGLE_R : WAIT_MULTI_R;
            end
         end else if (st_ff == S_DAT) begin
            if (sp_first) begin
               lo_ff <= mem_rdata; phase_ff <= 1'b1;
            end else begin
               if (ext_ff && plane_on && latch_en)
                  pat_ff[{plane_ff, pws_ff[plane_ff]}] <= mem_rdata;
               if (plane_more) begin
                  acc_ff <= acc_nx; plane_ff <= plane_ff + 2'd1;
               end else begin
                  // byte complete: rearm the per-byte state, advance to the next byte
                  acc_ff <= 8'hff; plane_ff <= 2'd0; phase_ff <= 1'b0;
                  if (ext_ff && amb_ff[2]) begin
                     if (is_wr) prs_ff <= ~prs_ff;
                     if (latch_en) pws_ff <= ~pws_ff;
                  end
                  if (pair_ff) hi_data_ff <= sv_word[15:8];
                  rd_ff <= bval;
                  bsel_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_wait_cycles = rsp_wait_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                   && $stable(rsp_wait_cycles))
      else $error("response changed while stalled");
   a_no_ready_in_sweep: assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> !req_ready)
      else $error("request taken during store sweep");
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_ready)
      else $error("request taken while sequencing");
   a_wait_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wait_cycles <= 4'd8))
      else $error("wait cycles out of range");
endmodule
